// File: rtl/core/led_pixel_spi_pattern_encoder_assert.svh
// Assertion macros for the LED pixel line-pattern encoder, used by lpse_serialize.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef LED_PIXEL_SPI_PATTERN_ENCODER_ASSERT_SVH
`define LED_PIXEL_SPI_PATTERN_ENCODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LPSE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpse assertion failed");

// Next-cycle implication, checked outside reset.
`define LPSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpse assertion failed");

`endif

// File: rtl/core/lpse_pkg.sv
// Shared constants and types for the LED pixel line-pattern encoder.
// No dependencies.
`default_nettype none

package lpse_pkg;

  localparam int unsigned MAX_PIXELS      = 1024;
  localparam int unsigned BYTES_PER_PIXEL = 30;
  localparam int unsigned FULL_BRIGHTNESS = 100;

  // floor(x / 100) for x up to 255 * 100 is (x * 5243) >> 19.
  localparam int unsigned SCALE_RECIP = 5243;
  localparam int unsigned SCALE_SHIFT = 19;

  localparam logic [9:0] ZERO_PATTERN_RST = 10'b1110000000;
  localparam logic [9:0] ONE_PATTERN_RST  = 10'b1111111000;

  localparam logic [1:0] STRIP_ONE = 2'd1;
  localparam logic [1:0] STRIP_TWO = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ZERO_PATTERN = 2'd0;
  localparam logic [1:0] REG_ONE_PATTERN  = 2'd1;
  localparam logic [1:0] REG_STRIP_ONE    = 2'd2;
  localparam logic [1:0] REG_STRIP_TWO    = 2'd3;

  localparam int unsigned PATTERN_BITS = 10;
  localparam int unsigned COLOR_BITS   = 24;
  localparam int unsigned LINE_BITS    = PATTERN_BITS * COLOR_BITS;

  // One scaled pixel, handed from the scaling pipeline to the serializer.
  typedef struct packed {
    logic [1:0]  strip;
    logic [14:0] base;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  blue;
  } pix_t;

endpackage

`default_nettype wire

// File: rtl/core/led_pixel_spi_pattern_encoder.sv
// Top level of the LED pixel line-pattern encoder: configuration registers,
// scaling pipeline and serializer. Depends on lpse_pkg, lpse_scale, lpse_serialize.
//
//  Channel | Direction | Handshake            | Payload
//  in_     | input     | in_tvalid/in_tready  | tuser strip; tdata index, rgb, brightness
//  out_    | output    | out_tvalid/out_tready| tuser strip; tdata offset, byte; tlast
//  cfg_    | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A valid pixel gives 30 bytes, one per cycle from the output shift register
// while out_tready is high; the next pixel is taken as the last byte goes. The
// first byte is offered once the pixel has passed stages 0, 1 and 2 into the
// output register. A dropped pixel leaves stage 0 without waiting on the later
// stages. Reset clears all valid flags and restores the registers.
// A stall on out_ holds the byte and backs up the three pipeline stages in turn.
`default_nettype none

module led_pixel_spi_pattern_encoder #(
  parameter int unsigned PIXEL_CAP = lpse_pkg::MAX_PIXELS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // [1:0] strip
  input  wire logic [47:0] in_tdata,   // [9:0] pixel_index, [33:10] rgb_color,
                                       // [41:34] brightness, [47:42] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [1:0]       out_tuser,  // [1:0] out_strip
  output logic [23:0]      out_tdata,  // [14:0] byte_offset, [22:15] pattern_byte, [23] zero
  output logic             out_tlast,  // last_byte
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);
  import lpse_pkg::*;

  logic [9:0]  zero_pattern_r;
  logic [9:0]  one_pattern_r;
  logic [10:0] strip_one_len_r;
  logic [10:0] strip_two_len_r;

  logic        pix_valid, pix_take;
  pix_t        pix;
  logic [14:0] out_offset;
  logic [7:0]  out_byte;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_pattern_r  <= ZERO_PATTERN_RST;
      one_pattern_r   <= ONE_PATTERN_RST;
      strip_one_len_r <= 11'd0;
      strip_two_len_r <= 11'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ZERO_PATTERN: zero_pattern_r  <= cfg_data[9:0];
        REG_ONE_PATTERN:  one_pattern_r   <= cfg_data[9:0];
        REG_STRIP_ONE:    strip_one_len_r <= cfg_data;
        REG_STRIP_TWO:    strip_two_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  lpse_scale #(
    .PIXEL_CAP     (PIXEL_CAP)
  ) u_scale (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_strip      (in_tuser),
    .in_index      (in_tdata[9:0]),
    .in_rgb        (in_tdata[33:10]),
    .in_pct        (in_tdata[41:34]),
    .strip_one_len (strip_one_len_r),
    .strip_two_len (strip_two_len_r),
    .pix_valid     (pix_valid),
    .pix_take      (pix_take),
    .pix           (pix)
  );

  lpse_serialize u_serialize (
    .clk          (clk),
    .rst_n        (rst_n),
    .pix_valid    (pix_valid),
    .pix_take     (pix_take),
    .pix          (pix),
    .zero_pattern (zero_pattern_r),
    .one_pattern  (one_pattern_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_strip    (out_tuser),
    .out_offset   (out_offset),
    .out_byte     (out_byte),
    .out_last     (out_tlast)
  );

  assign out_tdata = {1'b0, out_byte, out_offset};

endmodule

`default_nettype wire

// File: rtl/core/lpse_scale.sv
// Input register, range check and brightness scaling pipeline.
// Depends on lpse_pkg.
`default_nettype none

module lpse_scale #(
  parameter int unsigned PIXEL_CAP = lpse_pkg::MAX_PIXELS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_strip,
  input  wire logic [9:0]        in_index,
  input  wire logic [23:0]       in_rgb,
  input  wire logic [7:0]        in_pct,
  input  wire logic [10:0]       strip_one_len,
  input  wire logic [10:0]       strip_two_len,
  output logic                   pix_valid,
  input  wire logic              pix_take,
  output lpse_pkg::pix_t         pix
);
  import lpse_pkg::*;

  // Stage 0: registered input item.
  logic        s0_v_r;
  logic [1:0]  s0_strip_r;
  logic [9:0]  s0_idx_r;
  logic [23:0] s0_rgb_r;
  logic [6:0]  s0_pct_r;
  // Stage 1: colour times percent.
  logic        s1_v_r;
  logic [1:0]  s1_strip_r;
  logic [14:0] s1_base_r;
  logic [14:0] s1_g_r, s1_r_r, s1_b_r;
  // Stage 2: scaled colour bytes.
  logic        s2_v_r;
  pix_t        s2_pix_r;

  logic        keep;
  logic [10:0] len_sel;
  logic        free2, free1, adv0, load1, load2;
  logic [6:0]  pct_sat;
  logic [27:0] g_w, r_w, b_w;

  always_comb begin
    case (s0_strip_r)
      STRIP_ONE: len_sel = strip_one_len;
      STRIP_TWO: len_sel = strip_two_len;
      default:   len_sel = 11'd0;
    endcase
    keep = ({1'b0, s0_idx_r} < len_sel) && ({1'b0, s0_idx_r} < 11'(PIXEL_CAP));
  end

  assign free2    = !s2_v_r || pix_take;
  assign load2    = s1_v_r && free2;
  assign free1    = !s1_v_r || free2;
  assign load1    = s0_v_r && keep && free1;
  // A dropped item leaves stage 0 without going on.
  assign adv0     = s0_v_r && (!keep || free1);
  assign in_ready = !s0_v_r || adv0;

  assign pct_sat = (in_pct > 8'(FULL_BRIGHTNESS)) ? 7'(FULL_BRIGHTNESS) : in_pct[6:0];

  assign g_w = 28'(s1_g_r) * 28'(SCALE_RECIP);
  assign r_w = 28'(s1_r_r) * 28'(SCALE_RECIP);
  assign b_w = 28'(s1_b_r) * 28'(SCALE_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s0_v_r <= 1'b1;
      end else if (adv0) begin
        s0_v_r <= 1'b0;
      end
      if (load1) begin
        s1_v_r <= 1'b1;
      end else if (load2) begin
        s1_v_r <= 1'b0;
      end
      if (load2) begin
        s2_v_r <= 1'b1;
      end else if (pix_take) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_strip_r <= in_strip;
      s0_idx_r   <= in_index;
      s0_rgb_r   <= in_rgb;
      s0_pct_r   <= pct_sat;
    end
    if (load1) begin
      s1_strip_r <= s0_strip_r;
      s1_base_r  <= 15'(s0_idx_r) * 15'(BYTES_PER_PIXEL);
      s1_g_r     <= 15'(s0_rgb_r[15:8])  * 15'(s0_pct_r);
      s1_r_r     <= 15'(s0_rgb_r[23:16]) * 15'(s0_pct_r);
      s1_b_r     <= 15'(s0_rgb_r[7:0])   * 15'(s0_pct_r);
    end
    if (load2) begin
      s2_pix_r.strip <= s1_strip_r;
      s2_pix_r.base  <= s1_base_r;
      s2_pix_r.green <= g_w[SCALE_SHIFT +: 8];
      s2_pix_r.red   <= r_w[SCALE_SHIFT +: 8];
      s2_pix_r.blue  <= b_w[SCALE_SHIFT +: 8];
    end
  end

  assign pix_valid = s2_v_r;
  assign pix       = s2_pix_r;

endmodule

`default_nettype wire

// File: rtl/core/lpse_serialize.sv
// Line-pattern expansion and byte serializer with registered output.
// Depends on lpse_pkg and led_pixel_spi_pattern_encoder_assert.svh.
`default_nettype none

module lpse_serialize (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          pix_valid,
  output logic               pix_take,
  input  wire lpse_pkg::pix_t pix,
  input  wire logic [9:0]    zero_pattern,
  input  wire logic [9:0]    one_pattern,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         out_strip,
  output logic [14:0]        out_offset,
  output logic [7:0]         out_byte,
  output logic               out_last
);
  import lpse_pkg::*;

  localparam logic [4:0] LAST_BYTE = 5'(BYTES_PER_PIXEL - 1);

  logic                 busy_r;
  logic [4:0]           count_r;
  logic [14:0]          offset_r;
  logic [1:0]           strip_r;
  logic [LINE_BITS-1:0] line_r;

  logic [COLOR_BITS-1:0] color;
  logic [LINE_BITS-1:0]  line_w;
  logic                  xfer, is_last, load;

  // Green is sent first, so it sits at the top of the line word.
  assign color = {pix.green, pix.red, pix.blue};

  always_comb begin
    for (int j = 0; j < COLOR_BITS; j++) begin
      line_w[PATTERN_BITS*j +: PATTERN_BITS] = color[j] ? one_pattern : zero_pattern;
    end
  end

  assign is_last  = (count_r == LAST_BYTE);
  assign xfer     = busy_r && out_ready;
  assign pix_take = !busy_r || (xfer && is_last);
  assign load     = pix_take && pix_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      count_r <= 5'd0;
    end else if (load) begin
      busy_r  <= 1'b1;
      count_r <= 5'd0;
    end else if (xfer) begin
      if (is_last) begin
        busy_r <= 1'b0;
      end
      count_r <= count_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      line_r   <= line_w;
      offset_r <= pix.base;
      strip_r  <= pix.strip;
    end else if (xfer) begin
      line_r   <= {line_r[LINE_BITS-9:0], 8'd0};
      offset_r <= offset_r + 15'd1;
    end
  end

  assign out_valid  = busy_r;
  assign out_strip  = strip_r;
  assign out_offset = offset_r;
  assign out_byte   = line_r[LINE_BITS-1 -: 8];
  assign out_last   = is_last;

`include "led_pixel_spi_pattern_encoder_assert.svh"

  `LPSE_ASSERT_NOW(a_count_range, busy_r, count_r <= LAST_BYTE)
  `LPSE_ASSERT_NEXT(a_load_starts, load, busy_r && count_r == 5'd0)
  `LPSE_ASSERT_NEXT(a_offset_steps, xfer && !is_last, offset_r == $past(offset_r) + 15'd1)
  `LPSE_ASSERT_NEXT(a_idle_after_last, xfer && is_last && !pix_valid, !busy_r)

endmodule

`default_nettype wire

// File: bench/tb_led_pixel_spi_pattern_encoder.sv
// Self-checking testbench for led_pixel_spi_pattern_encoder: pixels go in, and every
// line-pattern byte that comes out is checked against a predictor kept in this file.
// Depends on lpse_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module tb_led_pixel_spi_pattern_encoder;
  import lpse_pkg::*;

  localparam logic [1:0] STRIP_NONE   = 2'd0;
  localparam logic [1:0] STRIP_BAD    = 2'd3;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RANDOM_PER_PHASE = 24;

  typedef struct packed {
    logic [1:0]  strip;
    logic [9:0]  idx;
    logic [23:0] rgb;
    logic [7:0]  bright;
    logic        drain;  // hold this pixel back until all bytes have arrived
  } pixel_t;

  typedef struct packed {
    logic [1:0]  strip;
    logic [14:0] offset;
    logic [7:0]  pattern;
    logic        last;
  } line_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;   // [1:0] strip
  logic [47:0] in_tdata = '0;   // [9:0] pixel_index, [33:10] rgb_color, [41:34] brightness
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [1:0]  out_tuser;       // [1:0] out_strip
  logic [23:0] out_tdata;       // [14:0] byte_offset, [22:15] pattern_byte
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  // Shadow copy of the configuration registers.
  logic [9:0]  zero_pat = ZERO_PATTERN_RST;
  logic [9:0]  one_pat = ONE_PATTERN_RST;
  logic [10:0] strip_one_len = '0;
  logic [10:0] strip_two_len = '0;

  pixel_t      pixel_queue[$];
  line_byte_t  pending_bytes[$];
  line_byte_t  want;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count = 0;

  led_pixel_spi_pattern_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void report_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // Usable pixel count of a strip; an unknown strip has none.
  function automatic int unsigned strip_span(input logic [1:0] strip);
    int unsigned len;
    if (strip == STRIP_ONE) len = strip_one_len;
    else if (strip == STRIP_TWO) len = strip_two_len;
    else len = 0;
    return (len > MAX_PIXELS) ? MAX_PIXELS : len;
  endfunction

  function automatic void encode_pixel(input pixel_t p);
    int unsigned span;
    int unsigned pct;
    logic [7:0] chan [3];
    logic [239:0] line;
    line_byte_t b;
    span = strip_span(p.strip);
    if (p.idx >= span) return;
    pct = (p.bright > FULL_BRIGHTNESS) ? FULL_BRIGHTNESS : p.bright;
    chan[0] = 8'((p.rgb[15:8] * pct) / FULL_BRIGHTNESS);
    chan[1] = 8'((p.rgb[23:16] * pct) / FULL_BRIGHTNESS);
    chan[2] = 8'((p.rgb[7:0] * pct) / FULL_BRIGHTNESS);
    line = '0;
    for (int c = 0; c < 3; c++) begin
      for (int i = 7; i >= 0; i--) begin
        line = {line[229:0], chan[c][i] ? one_pat : zero_pat};
      end
    end
    for (int k = 0; k < BYTES_PER_PIXEL; k++) begin
      b.strip = p.strip;
      b.offset = 15'(p.idx * BYTES_PER_PIXEL + k);
      b.pattern = line[239 - 8 * k -: 8];
      b.last = (k == BYTES_PER_PIXEL - 1);
      pending_bytes.push_back(b);
    end
  endfunction

  // Pixel driver: a presented pixel is held until its transfer completes.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_tvalid) begin
        encode_pixel(pixel_queue[0]);
        void'(pixel_queue.pop_front());
      end
      if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          !(pixel_queue[0].drain && pending_bytes.size() != 0)) begin
        in_tuser <= pixel_queue[0].strip;
        in_tdata <= {6'b0, pixel_queue[0].bright, pixel_queue[0].rgb, pixel_queue[0].idx};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Byte monitor with random back-pressure.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bytes.size() == 0) begin
        report_failure($sformatf("unexpected byte: strip %0d offset %0d data %02h last %0b",
                                 out_tuser, out_tdata[14:0], out_tdata[22:15], out_tlast));
      end else begin
        want = pending_bytes.pop_front();
        if (out_tuser !== want.strip || out_tdata[14:0] !== want.offset ||
            out_tdata[22:15] !== want.pattern || out_tlast !== want.last) begin
          report_failure($sformatf(
            "byte mismatch: expected strip %0d offset %0d data %02h last %0b, got %0d %0d %02h %0b",
            want.strip, want.offset, want.pattern, want.last,
            out_tuser, out_tdata[14:0], out_tdata[22:15], out_tlast));
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
          $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ZERO_PATTERN: zero_pat = val[9:0];
      REG_ONE_PATTERN:  one_pat = val[9:0];
      REG_STRIP_ONE:    strip_one_len = val;
      REG_STRIP_TWO:    strip_two_len = val;
      default: ;
    endcase
  endtask

  task automatic add_pixel(input logic [1:0] strip, input logic [9:0] idx,
                           input logic [23:0] rgb, input logic [7:0] bright);
    pixel_queue.push_back('{strip: strip, idx: idx, rgb: rgb, bright: bright, drain: 1'b0});
  endtask

  // Mostly in-range pixels; the rest target a bad strip or run past the strip end.
  // The pixel in the middle of each batch always waits for the output to drain.
  task automatic add_random_pixels(input int unsigned count);
    pixel_t p;
    int unsigned span;
    int unsigned roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      p.strip = $urandom_range(1) ? STRIP_TWO : STRIP_ONE;
      span = strip_span(p.strip);
      if (roll < 85 && span > 0) begin
        p.idx = ($urandom_range(7) == 0) ? 10'(span - 1) : 10'($urandom_range(span - 1));
      end else if (roll < 92 || span >= MAX_PIXELS) begin
        p.strip = $urandom_range(1) ? STRIP_BAD : STRIP_NONE;
        p.idx = 10'($urandom);
      end else begin
        p.idx = 10'($urandom_range(MAX_PIXELS - 1, span));
      end
      p.rgb = 24'($urandom);
      p.bright = ($urandom_range(3) == 0) ? 8'($urandom_range(255, 101)) :
                                            8'($urandom_range(100));
      p.drain = (n == count / 2) || ($urandom_range(19) == 0);
      pixel_queue.push_back(p);
    end
  endtask

  // Waits until every pixel has been taken and every byte has arrived; dropped
  // pixels produce nothing, so it then waits a further settling period until the block is idle.
  task automatic settle();
    while (pixel_queue.size() != 0 || in_tvalid || pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Both strips are empty after reset, so this pixel is dropped.
    add_pixel(STRIP_ONE, 10'd0, 24'hFFFFFF, 8'd100);
    settle();

    // Reset patterns, full strip one, strip two length saturating at capacity.
    write_reg(REG_STRIP_ONE, 11'd1024);
    write_reg(REG_STRIP_TWO, 11'd2047);
    add_pixel(STRIP_ONE, 10'd0, 24'h000000, 8'd100);
    add_pixel(STRIP_ONE, 10'd1023, 24'hFFFFFF, 8'd100);
    add_pixel(STRIP_TWO, 10'd1023, 24'hFFFFFF, 8'd255);
    add_pixel(STRIP_TWO, 10'd0, 24'hFF0000, 8'd101);
    add_pixel(STRIP_ONE, 10'd512, 24'h00FF00, 8'd50);
    add_pixel(STRIP_TWO, 10'd341, 24'h0000FF, 8'd0);
    add_pixel(STRIP_NONE, 10'd0, 24'hFFFFFF, 8'd100);
    add_pixel(STRIP_BAD, 10'd1023, 24'hFFFFFF, 8'd100);
    add_pixel(STRIP_ONE, 10'd682, 24'hA55A3C, 8'd99);
    add_pixel(STRIP_TWO, 10'd1, 24'h123456, 8'd1);
    settle();

    // Extreme patterns, a short strip one and an empty strip two.
    write_reg(REG_ZERO_PATTERN, 11'd0);
    write_reg(REG_ONE_PATTERN, 11'd1023);
    write_reg(REG_STRIP_ONE, 11'd5);
    write_reg(REG_STRIP_TWO, 11'd0);
    add_pixel(STRIP_ONE, 10'd4, 24'hA5C35A, 8'd100);
    add_pixel(STRIP_ONE, 10'd5, 24'hFFFFFF, 8'd100);
    add_pixel(STRIP_TWO, 10'd0, 24'hFFFFFF, 8'd100);
    add_pixel(STRIP_ONE, 10'd0, 24'hFFFFFF, 8'd255);
    add_pixel(STRIP_ONE, 10'd1023, 24'h5A5A5A, 8'd100);
    settle();

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
          write_reg(REG_ZERO_PATTERN, 11'(ZERO_PATTERN_RST));
          write_reg(REG_ONE_PATTERN, 11'(ONE_PATTERN_RST));
          write_reg(REG_STRIP_ONE, 11'd1024);
          write_reg(REG_STRIP_TWO, 11'd1024);
        end
        1: begin
          send_idle_pct = 83;
          stall_pct = 0;
          write_reg(REG_ZERO_PATTERN, 11'($urandom_range(1023)));
          write_reg(REG_ONE_PATTERN, 11'($urandom_range(1023)));
          write_reg(REG_STRIP_ONE, 11'($urandom_range(1024, 1)));
          write_reg(REG_STRIP_TWO, 11'd2047);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 83;
          write_reg(REG_ZERO_PATTERN, 11'd1023);
          write_reg(REG_ONE_PATTERN, 11'd0);
          write_reg(REG_STRIP_ONE, 11'd1);
          write_reg(REG_STRIP_TWO, 11'd300);
        end
        default: begin
          send_idle_pct = 31;
          stall_pct = 31;
          write_reg(REG_ZERO_PATTERN, 11'($urandom_range(1023)));
          write_reg(REG_ONE_PATTERN, 11'($urandom_range(1023)));
          write_reg(REG_STRIP_ONE, 11'($urandom_range(2047, 1)));
          write_reg(REG_STRIP_TWO, 11'($urandom_range(2047, 1)));
        end
      endcase
      add_random_pixels(RANDOM_PER_PHASE);
      settle();
    end

    if (pending_bytes.size() != 0)
      report_failure($sformatf("%0d expected bytes never arrived", pending_bytes.size()));
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
